[hw/rtl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on clk, disabled during rst.
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also runs during reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/hprt_pkg.sv]
package hprt_pkg;
  localparam int NUM_CHIPS_DEF = 4;
  localparam int ENTRIES_PER_CHIP_DEF = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_BITS = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_BAD_CHIP  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;
endpackage

[hw/rtl/hot_pixel_region_table.sv]
// Hot-pixel region table.
// One sorted table of rectangles per chip, held in one synchronous memory
// (NUM_CHIPS * ENTRIES_PER_CHIP words of four bounds). Per-chip counts live
// in flip-flops and are cleared by rst; the memory needs no clearing.
// Input channel s_axis: mode in tuser, other fields in tdata. Output channel
// m_axis: one item per input, hot and insert_status in tdata.
// An insert scans the chip's table from entry 0, one memory read per cycle,
// until it reaches the first entry whose key is not below the new key. An
// equal rectangle there is answered as duplicate and a full table as full;
// else it shifts the tail up one place, one entry at a time (read, then
// write), and writes the new rectangle. A check scans from entry 0 until
// an entry's x_low exceeds the event x, a hit is found or the entries run
// out. An invalid chip skips the scan. One item is in work at a time; the
// memory port sets the rate. The result sits in an output register; while
// m_axis_tready is low the block holds it and takes no new item.
module hot_pixel_region_table
  import hprt_pkg::*;
#(
  parameter int NUM_CHIPS = NUM_CHIPS_DEF,
  parameter int ENTRIES_PER_CHIP = ENTRIES_PER_CHIP_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // chip[3:0], x_low, x_high, y_low, y_high, event_x, event_y (16 bits each)
  input  logic [103:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hot, insert_status[1:0], zero fill
  output logic [7:0]   m_axis_tdata
);
  `include "assert_macros.svh"

  localparam int CW = $clog2(ENTRIES_PER_CHIP + 1);
  localparam int CHW = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
  localparam int DEPTH = NUM_CHIPS * ENTRIES_PER_CHIP;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = 4 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t xl;
    coord_t xh;
    coord_t yl;
    coord_t yh;
  } rect_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_PUT   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [RW-1:0] mem [DEPTH];
  rect_t rd_data;
  logic mem_we;
  logic [AW-1:0] wr_addr, rd_addr;
  rect_t wr_data;

  logic [CW-1:0] counts [NUM_CHIPS];
  logic mode;
  logic [CHW-1:0] chip;
  rect_t nrect;
  coord_t ex, ey;
  logic [CW-1:0] cnt;    // count of the chip in work
  logic [CW-1:0] idx;    // entry being read
  logic [CW-1:0] pos;    // insert position
  logic rd_pend;         // rd_data holds entry idx-1
  logic hot;
  status_t status;

  logic [3:0] in_chip;
  assign in_chip = s_axis_tdata[3:0];
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {5'd0, status, hot};

  function automatic logic [AW-1:0] addr_of(input logic [CHW-1:0] c, input logic [CW-1:0] e);
    logic [AW+CW-1:0] a;
    a = AW'(c) * (AW+CW)'(ENTRIES_PER_CHIP) + (AW+CW)'(e);
    return a[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Key and match tests on the entry just read.
  logic key_below, same_rect, x_past, ev_hit;
  assign key_below = (rd_data.xl < nrect.xl) ||
                     (rd_data.xl == nrect.xl && rd_data.yl < nrect.yl);
  assign same_rect = (rd_data == nrect);
  assign x_past = rd_data.xl > ex;
  assign ev_hit = rd_data.xh >= ex && rd_data.yl <= ey && rd_data.yh >= ey;

  always_comb begin
    rd_addr = addr_of(chip, idx);
    mem_we = 1'b0;
    wr_addr = addr_of(chip, idx);
    wr_data = rd_data;
    case (state)
      S_SHWR: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we = 1'b1;
        wr_addr = addr_of(chip, pos);
        wr_data = nrect;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_pend <= 1'b0;
      for (int i = 0; i < NUM_CHIPS; i++) counts[i] <= '0;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          mode <= s_axis_tuser;
          chip <= CHW'(in_chip);
          nrect.xl <= coord_t'(s_axis_tdata[4 +: COORD_BITS]);
          nrect.xh <= coord_t'(s_axis_tdata[20 +: COORD_BITS]);
          nrect.yl <= coord_t'(s_axis_tdata[36 +: COORD_BITS]);
          nrect.yh <= coord_t'(s_axis_tdata[52 +: COORD_BITS]);
          ex <= coord_t'(s_axis_tdata[68 +: COORD_BITS]);
          ey <= coord_t'(s_axis_tdata[84 +: COORD_BITS]);
          hot <= 1'b0;
          idx <= '0;
          rd_pend <= 1'b0;
          if (32'(in_chip) >= NUM_CHIPS) begin
            status <= (s_axis_tuser == MODE_INSERT) ? ST_BAD_CHIP : ST_INSERTED;
            state <= S_OUT;
          end else begin
            status <= ST_INSERTED;
            cnt <= counts[CHW'(in_chip)];
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Address idx goes out this cycle; rd_data holds entry idx-1.
          if (rd_pend) begin
            if (mode == MODE_CHECK) begin
              if (x_past) state <= S_OUT;
              else if (ev_hit) begin
                hot <= 1'b1;
                state <= S_OUT;
              end
            end else if (!key_below) begin
              pos <= idx - 1'b1;
              if (same_rect) begin
                status <= ST_DUPLICATE;
                state <= S_OUT;
              end else state <= S_DEC;
            end
          end
          if (state == S_SCAN && !(rd_pend && (mode == MODE_CHECK ? (x_past || ev_hit)
                                                : !key_below))) begin
            if (idx == cnt) begin
              // Walked past the last entry.
              pos <= cnt;
              if (mode == MODE_CHECK) state <= S_OUT;
              else state <= S_DEC;
            end else begin
              idx <= idx + 1'b1;
              rd_pend <= 1'b1;
            end
          end
        end
        S_DEC: begin
          if (32'(cnt) >= ENTRIES_PER_CHIP) begin
            status <= ST_FULL;
            state <= S_OUT;
          end else if (cnt == pos) begin
            state <= S_PUT;
          end else begin
            idx <= cnt - 1'b1;
            state <= S_SHRD;
          end
        end
        S_SHRD: begin
          // Read of entry idx issued; next cycle write it at idx+1.
          idx <= idx + 1'b1;
          state <= S_SHWR;
        end
        S_SHWR: begin
          if (idx - 1'b1 == pos) state <= S_PUT;
          else begin
            idx <= idx - 2'd2;
            state <= S_SHRD;
          end
        end
        S_PUT: begin
          counts[chip] <= cnt + 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
  `CHK(a_no_overlap, s_axis_tready |-> !m_axis_tvalid, "input taken while result pending")
  `CHK(a_hot_check_only, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'd0, "hot set with nonzero status")
  `CHK(a_put_room, state == S_PUT |-> 32'(cnt) < ENTRIES_PER_CHIP, "insert into full table")
endmodule
